// ===== sv/stcc_pkg.sv =====
package stcc_pkg;

    localparam int COUNT_W             = 11;
    localparam int WORD_W              = 32;
    localparam int ENTRY_W             = 10;
    localparam int CFG_IDX_W           = 1;
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ENTRY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch start entry, zero walk counters
        logic tbl_wr;   // store one successor word
        logic clear;    // clear one visited bit
        logic read;     // fetch successor and visited bit at current entry
        logic advance;  // mark current entry visited, step to its successor
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bad_cfg;
        logic clear_last;
        logic cur_oob;
        logic seen;
        logic step_last;
        logic at_start;
    } status_t;

endpackage

// ===== sv/stcc_ram.sv =====
module stcc_ram #(
    parameter int WIDTH = stcc_pkg::WORD_W,
    parameter int DEPTH = stcc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/stcc_datapath.sv =====
module stcc_datapath #(
    parameter int TABLE_DEPTH = stcc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [stcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stcc_pkg::WORD_W-1:0]    cfg_data,
    input  logic [stcc_pkg::ENTRY_W-1:0]   s_entry_index,
    input  logic [stcc_pkg::WORD_W-1:0]    s_successor,
    input  stcc_pkg::cmd_t                 cmd,
    output stcc_pkg::status_t              status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [stcc_pkg::COUNT_W-1:0] entry_count_reg;
    logic [stcc_pkg::WORD_W-1:0]  start_entry_reg;
    logic [stcc_pkg::WORD_W-1:0]  cur_reg;
    logic [stcc_pkg::COUNT_W-1:0] step_reg;
    logic [IDX_W-1:0]             clr_reg;

    logic [stcc_pkg::WORD_W-1:0]  entry_idx_ext;
    logic [stcc_pkg::WORD_W-1:0]  count_ext;
    logic [stcc_pkg::WORD_W-1:0]  table_depth_ext;
    logic                         tbl_we;
    logic [IDX_W-1:0]             cur_addr;
    logic [stcc_pkg::WORD_W-1:0]  succ_rdata;
    logic                         vis_we;
    logic [IDX_W-1:0]             vis_waddr;
    logic                         vis_rdata;

    assign entry_idx_ext   = stcc_pkg::WORD_W'(s_entry_index);
    assign count_ext       = stcc_pkg::WORD_W'(entry_count_reg);
    assign table_depth_ext = stcc_pkg::WORD_W'(TABLE_DEPTH);
    assign tbl_we          = cmd.tbl_wr && (entry_idx_ext < table_depth_ext);
    assign cur_addr        = cur_reg[IDX_W-1:0];

    // clearing and marking share the visited write port
    assign vis_we    = cmd.clear || cmd.advance;
    assign vis_waddr = cmd.clear ? clr_reg : cur_addr;

    stcc_ram #(
        .WIDTH (stcc_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_succ_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (entry_idx_ext[IDX_W-1:0]),
        .wdata (s_successor),
        .raddr (cur_addr),
        .rdata (succ_rdata)
    );

    stcc_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_DEPTH)
    ) u_visited_ram (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (!cmd.clear),
        .raddr (cur_addr),
        .rdata (vis_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            start_entry_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                stcc_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_data[stcc_pkg::COUNT_W-1:0];
                stcc_pkg::CFG_START_ENTRY: start_entry_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg  <= start_entry_reg;
            step_reg <= '0;
            clr_reg  <= '0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            if (cmd.advance) begin
                cur_reg  <= succ_rdata;
                step_reg <= step_reg + stcc_pkg::COUNT_W'(1);
            end
        end
    end

    always_comb begin
        status.bad_cfg    = (entry_count_reg == '0) || (count_ext > table_depth_ext) ||
                            (start_entry_reg >= count_ext);
        status.clear_last = stcc_pkg::WORD_W'(clr_reg) == (count_ext - stcc_pkg::WORD_W'(1));
        status.cur_oob    = cur_reg >= count_ext;
        status.seen       = vis_rdata;
        status.step_last  = step_reg == (entry_count_reg - stcc_pkg::COUNT_W'(1));
        status.at_start   = cur_reg == start_entry_reg;
    end

    a_advance_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> $past(cmd.read))
        else $error("advance without a preceding table read");

    a_clear_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> (stcc_pkg::WORD_W'(clr_reg) < count_ext))
        else $error("visited clear beyond entry count");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.read |-> !status.cur_oob)
        else $error("table read at an out-of-range entry");

endmodule

// ===== sv/stcc_ctrl.sv =====
module stcc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_cycle_ok,
    output stcc_pkg::cmd_t    cmd,
    input  stcc_pkg::status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_READ  = 6'b000100,
        ST_EVAL  = 6'b001000,
        ST_FINAL = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   verdict_reg, verdict_next;
    logic   m_valid_reg, m_valid_next;
    logic   m_cycle_ok_reg, m_cycle_ok_next;
    logic   accept;
    logic   out_free;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_cycle_ok = m_cycle_ok_reg;

    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        verdict_next = verdict_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == stcc_pkg::OP_CHECK) begin
                        cmd.load = 1'b1;
                        if (status.bad_cfg) begin
                            verdict_next = 1'b0;
                            state_next   = ST_DONE;
                        end else begin
                            state_next = ST_CLEAR;
                        end
                    end else begin
                        cmd.tbl_wr = 1'b1;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (status.cur_oob) begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end else begin
                    cmd.read   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (status.seen) begin
                    verdict_next = 1'b0;
                    state_next   = ST_DONE;
                end else begin
                    cmd.advance = 1'b1;
                    state_next  = status.step_last ? ST_FINAL : ST_READ;
                end
            end
            ST_FINAL: begin
                verdict_next = status.at_start;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_cycle_ok_next = m_cycle_ok_reg;
        if (state_reg == ST_DONE && out_free) begin
            m_valid_next    = 1'b1;
            m_cycle_ok_next = verdict_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg    <= verdict_next;
        m_cycle_ok_reg <= m_cycle_ok_next;
    end

    a_bad_cfg_fails: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_op == stcc_pkg::OP_CHECK && status.bad_cfg
        |=> state_reg == ST_DONE && !verdict_reg)
        else $error("bad configuration did not fail at once");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && out_free
        |=> m_valid_reg && m_cycle_ok_reg == $past(verdict_reg))
        else $error("verdict not moved to output register");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

endmodule

// ===== sv/successor_table_cycle_checker.sv =====
// Channel  | Handshake           | Payload                            | Moves
// cfg      | cfg_we              | cfg_index, cfg_data                | register write
// s_       | s_valid / s_ready   | s_op, s_entry_index, s_successor   | write or check request
// m_       | m_valid / m_ready   | m_cycle_ok                         | one verdict per check
//
// Table write: one request per cycle while no check is running, no result.
// Check: a start step, then clearing of the visited map one entry at a time, then
//   walk steps (registered table read, then evaluate), then a final compare with
//   the start entry; a bad configuration fails without clearing or walking.
// s_ready is low for the whole check; the verdict waits in an output register.
// aresetn is synchronous, active low; table contents survive reset.
module successor_table_cycle_checker #(
    parameter int TABLE_DEPTH = stcc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [stcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [stcc_pkg::WORD_W-1:0]    cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [stcc_pkg::ENTRY_W-1:0]   s_entry_index,
    input  logic [stcc_pkg::WORD_W-1:0]    s_successor,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_cycle_ok
);

    stcc_pkg::cmd_t    cmd;
    stcc_pkg::status_t status;

    stcc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_cycle_ok (m_cycle_ok),
        .cmd        (cmd),
        .status     (status)
    );

    stcc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_entry_index (s_entry_index),
        .s_successor   (s_successor),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
